// File: rtl/utf8_to_utf16_stream_assert.svh
// Assertion macros used by the checker of the transcoder.
`ifndef UTF8_TO_UTF16_STREAM_ASSERT_SVH
`define UTF8_TO_UTF16_STREAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define U8U16_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define U8U16_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

// Implication checked even on the edge at which reset is released.
`define U8U16_ASSERT_RAW(label, ck, ante, cons, msg) \
	label: assert property (@(posedge ck) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Widths and constants shared by the UTF-8 to UTF-16 transcoder and its checker.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam int BYTE_W = 8;
	localparam int UNIT_W = 16;
	localparam int CP_W   = 32;
	localparam int REC_N  = 3;
	localparam int REC_CW = $clog2(REC_N + 1);

	localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
	localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [CP_W-1:0]   SUPP_OFFSET  = 32'h0001_0000;
	localparam logic [UNIT_W-1:0] TERMINATOR   = 16'h0000;

	// Leading six bits of a high surrogate unit.
	localparam logic [5:0] HI_SURR_TAG = 6'b110110;

endpackage

// File: rtl/utf8_to_utf16_stream.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream
// Converts a stream of UTF-8 bytes into a stream of UTF-16 code units.
// ----------------------------------------------------------------------------
// Input items are single bytes on data_byte with last_byte, taken with
// in_valid and in_ready. Output items are single UTF-16 units on code_unit
// with end_of_string, offered with out_valid and out_ready.
// The bit written through cfg_we and cfg_wdata selects counted mode, in
// which the string ends after the sequence holding the marked last byte and
// a zero terminator follows; otherwise the string ends on code point zero.
// The byte that completes a sequence is decoded in the cycle it is taken
// and its one to three units are held in a small result buffer; the first
// unit moves on into the output register once that register is empty or being read.
// One byte is taken per cycle while each item yields at most one unit and
// the receiver is ready. Surrogate pairs and terminators hold the input
// while their extra units wait in the buffer, as the output register passes
// one unit per cycle while the receiver is ready.
// When the receiver stalls, the output unit holds, the buffer fills, and
// in_ready falls; nothing is lost.
// Reset clears the decoder state, the buffer, the output valid and the mode.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [u8u16_pkg::BYTE_W-1:0]  data_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [u8u16_pkg::UNIT_W-1:0]  code_unit,
	output logic                          end_of_string
);
	import u8u16_pkg::*;

	logic              counted_q;
	logic [CP_W-1:0]   partial_q;
	logic [2:0]        rem_q;
	logic              endp_q;

	logic [UNIT_W-1:0] rec_unit_q [REC_N];
	logic              rec_eos_q  [REC_N];
	logic [REC_CW-1:0] rec_cnt_q;

	logic              out_valid_q;
	logic [UNIT_W-1:0] out_unit_q;
	logic              out_eos_q;

	logic              accept;
	logic              pop;
	logic [3:0]        lz;
	logic [BYTE_W-1:0] lead_mask;
	logic [CP_W-1:0]   cp_n;
	logic [2:0]        rem_n;
	logic              endp_n;
	logic              complete;
	logic              ends;
	logic              single;
	logic [CP_W-1:0]   v;
	logic [UNIT_W-1:0] new_unit [REC_N];
	logic              new_eos  [REC_N];
	logic [REC_CW-1:0] new_cnt;

	assign pop      = (rec_cnt_q != '0) && (!out_valid_q || out_ready);
	assign in_ready = (rec_cnt_q == '0) || ((rec_cnt_q == REC_CW'(1)) && pop);
	assign accept   = in_valid && in_ready;

	// The highest zero bit of the byte fixes the count of leading ones.
	always_comb begin
		lz = 4'd8;
		for (int i = 0; i < BYTE_W; i++) begin
			if (!data_byte[i]) begin
				lz = 4'(BYTE_W - 1 - i);
			end
		end
	end

	assign lead_mask = BYTE_W'(8'hFF >> (lz + 4'd1));

	always_comb begin
		if (rem_q == 3'd0) begin
			cp_n  = {{(CP_W-BYTE_W){1'b0}}, data_byte & lead_mask};
			rem_n = (lz == 4'd0) ? 3'd0 : 3'(lz - 4'd1);
		end else begin
			cp_n  = {partial_q[CP_W-7:0], data_byte[5:0]};
			rem_n = rem_q - 3'd1;
		end
	end

	assign endp_n   = endp_q || (counted_q && last_byte);
	assign complete = (rem_n == 3'd0);
	assign ends     = counted_q ? endp_n : (cp_n == '0);
	assign single   = (cp_n[CP_W-1:UNIT_W] == '0) && (cp_n[15:11] != 5'b11011);
	assign v        = cp_n - SUPP_OFFSET;

	always_comb begin
		new_unit[0] = cp_n[UNIT_W-1:0];
		new_eos[0]  = ends && !counted_q;
		new_unit[1] = TERMINATOR;
		new_eos[1]  = 1'b1;
		new_unit[2] = TERMINATOR;
		new_eos[2]  = 1'b1;
		new_cnt     = REC_CW'(1);
		if (!single) begin
			new_unit[0] = HI_SURR_BASE | {6'b0, v[19:10]};
			new_eos[0]  = 1'b0;
			new_unit[1] = LO_SURR_BASE | {6'b0, v[9:0]};
			new_eos[1]  = ends && !counted_q;
			new_cnt     = REC_CW'(2);
		end
		if (ends && counted_q) begin
			new_cnt = new_cnt + REC_CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counted_q <= 1'b0;
		end else if (cfg_we) begin
			counted_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			rem_q     <= 3'd0;
			endp_q    <= 1'b0;
		end else if (accept) begin
			rem_q <= rem_n;
			if (complete) begin
				partial_q <= '0;
				endp_q    <= 1'b0;
			end else begin
				partial_q <= cp_n;
				endp_q    <= endp_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_cnt_q <= '0;
		end else if (accept) begin
			rec_cnt_q <= complete ? new_cnt : '0;
		end else if (pop) begin
			rec_cnt_q <= rec_cnt_q - REC_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && complete) begin
			for (int i = 0; i < REC_N; i++) begin
				rec_unit_q[i] <= new_unit[i];
				rec_eos_q[i]  <= new_eos[i];
			end
		end else if (pop) begin
			for (int i = 0; i < REC_N - 1; i++) begin
				rec_unit_q[i] <= rec_unit_q[i+1];
				rec_eos_q[i]  <= rec_eos_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_unit_q <= rec_unit_q[0];
			out_eos_q  <= rec_eos_q[0];
		end
	end

	assign out_valid     = out_valid_q;
	assign code_unit     = out_unit_q;
	assign end_of_string = out_eos_q;

endmodule

// File: rtl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the UTF-8 to UTF-16 transcoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_stream_assert.svh"

module u8u16_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [u8u16_pkg::UNIT_W-1:0]  code_unit,
	input  logic                          end_of_string
);
	import u8u16_pkg::*;

	`U8U16_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(code_unit) && $stable(end_of_string),
		"Stalled output item changed.")

	`U8U16_ASSERT_NOW(a_eos_is_zero, clk, arst_n, out_valid && end_of_string,
		code_unit == TERMINATOR, "End of string marked on a non-zero unit.")

	`U8U16_ASSERT_NOW(a_hi_surr_not_last, clk, arst_n,
		out_valid && (code_unit[15:10] == HI_SURR_TAG), !end_of_string,
		"String ended on a high surrogate.")

	`U8U16_ASSERT_RAW(a_reset_idle, clk, $rose(arst_n), !out_valid,
		"Output valid directly after reset.")

endmodule

bind utf8_to_utf16_stream u8u16_checker u_u8u16_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.code_unit     (code_unit),
	.end_of_string (end_of_string)
);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream transcoder testbench
// Feeds UTF-8 bytes through the valid/ready input and decodes them in a
// scoreboard that predicts every UTF-16 unit, end marker and terminator.
// Directed bytes cover the corner cases, then random strings run in both
// modes with random idling, a long receiver stall and idle mode switches.
// ----------------------------------------------------------------------------
module tb;
	import u8u16_pkg::*;

	typedef struct {
		logic [UNIT_W-1:0] unit;
		logic              eos;
	} unit_t;

	class utf16_scoreboard;
		logic              counted;
		logic [CP_W-1:0]   partial;
		logic [2:0]        remaining;
		logic              end_pending;
		unit_t             units_due[$];
		int                errors;

		function new();
			counted     = 1'b0;
			partial     = '0;
			remaining   = '0;
			end_pending = 1'b0;
			errors      = 0;
		endfunction

		function void set_mode(logic m);
			counted = m;
		endfunction

		function void push_unit(logic [UNIT_W-1:0] u, logic e);
			unit_t x;
			x.unit = u;
			x.eos  = e;
			units_due.push_back(x);
		endfunction

		// Decodes one accepted byte and queues the units it completes.
		function void note_byte(logic [BYTE_W-1:0] b, logic lastb);
			int              ones;
			logic [7:0]      mask;
			logic [CP_W-1:0] cp;
			logic [CP_W-1:0] v;
			logic            ends;
			if (remaining == 0) begin
				ones = 0;
				while (ones < 8 && b[7 - ones])
					ones++;
				mask = 8'hFF >> (ones + 1);
				partial = (ones >= 7) ? '0 : {24'b0, b & mask};
				remaining = (ones < 1) ? 3'd0 : 3'(ones - 1);
			end else begin
				partial = {partial[CP_W-7:0], b[5:0]};
				remaining = remaining - 3'd1;
			end
			if (counted && lastb)
				end_pending = 1'b1;
			if (remaining != 0)
				return;
			cp = partial;
			ends = counted ? end_pending : (cp == '0);
			if (cp <= 32'hD7FF || (cp >= 32'hE000 && cp <= 32'hFFFF)) begin
				push_unit(cp[UNIT_W-1:0], ends && !counted);
			end else begin
				v = cp - SUPP_OFFSET;
				push_unit(HI_SURR_BASE + {6'b0, v[19:10]}, 1'b0);
				push_unit(LO_SURR_BASE + {6'b0, v[9:0]}, ends && !counted);
			end
			if (ends && counted)
				push_unit(TERMINATOR, 1'b1);
			partial = '0;
			end_pending = 1'b0;
		endfunction

		function void check_unit(logic [UNIT_W-1:0] unit, logic eos);
			unit_t want;
			if (units_due.size() == 0) begin
				$error("unexpected code unit %h (end_of_string %b)", unit, eos);
				errors++;
				return;
			end
			want = units_due.pop_front();
			if (unit !== want.unit) begin
				$error("code_unit: expected %h, got %h", want.unit, unit);
				errors++;
			end
			if (eos !== want.eos) begin
				$error("end_of_string: expected %b, got %b", want.eos, eos);
				errors++;
			end
		endfunction

		function int pending();
			return units_due.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              cfg_we        = 1'b0;
	logic              cfg_wdata     = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] data_byte     = '0;
	logic              last_byte     = 1'b0;
	logic              out_valid;
	logic              out_ready     = 1'b0;
	logic [UNIT_W-1:0] code_unit;
	logic              end_of_string;

	utf16_scoreboard sb = new();
	bit              calm     = 1'b0;
	bit              hold_req = 1'b0;
	bit              mode_now = 1'b0;
	int              n_sent   = 0;

	utf8_to_utf16_stream u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.code_unit    (code_unit),
		.end_of_string(end_of_string)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_mode(cfg_wdata);
			if (in_valid && in_ready)
				sb.note_byte(data_byte, last_byte);
			if (out_valid && out_ready)
				sb.check_unit(code_unit, end_of_string);
		end
	end

	// The receiver; a hold request keeps it stalled for a long stretch.
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (120) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= calm || ($urandom_range(99) >= 14);
		end
	end

	initial begin : watchdog
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(logic [BYTE_W-1:0] b, logic lastb);
		if (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= lastb;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic send_char(int n, logic [CP_W-1:0] cp, int last_at);
		logic [7:0] lead;
		logic [7:0] cont;
		int         k;
		if (n == 1) begin
			lead = {1'b0, cp[6:0]};
		end else begin
			lead = 8'hFF << (8 - n);
			if (n < 7)
				lead = lead | (8'(cp >> (6 * (n - 1))) & (8'hFF >> (n + 1)));
		end
		send_byte(lead, last_at == 0);
		for (k = n - 2; k >= 0; k--) begin
			cont = {2'b10, 6'(cp >> (6 * k))};
			if ($urandom_range(19) == 0)
				cont = 8'($urandom());
			send_byte(cont, last_at == n - 1 - k);
		end
	endtask

	// One random character; in counted mode a final one is marked unless stray.
	task automatic random_char(bit final_char);
		int              r;
		int              n;
		int              last_at;
		logic [CP_W-1:0] cp;
		r = $urandom_range(99);
		cp = $urandom();
		if (r >= 94) begin
			send_byte(8'($urandom()), mode_now ? 1'b0 : 1'($urandom()));
			return;
		end
		if (r < 35) n = 1;
		else if (r < 55) n = 2;
		else if (r < 75) n = 3;
		else if (r < 88) n = 4;
		else n = $urandom_range(5, 8);
		if (n < 7)
			cp = cp & ((32'd1 << (n == 1 ? 7 : 5 * n + 1)) - 1);
		if (!mode_now)
			last_at = $urandom_range(n) - 1;
		else if (!final_char)
			last_at = -1;
		else if ($urandom_range(4) == 0)
			last_at = $urandom_range(n - 1);
		else
			last_at = n - 1;
		send_char(n, cp, last_at);
	endtask

	task automatic wait_units_out(int tail);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic write_mode(logic m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		mode_now = m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		bit modes[6];
		int p;
		int c;
		int nchars;
		int goal;
		bit paused;
		modes = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Null mode corner cases.
		write_mode(1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		send_char(4, 32'h1F600, -1);
		send_char(3, 32'hD800, -1);
		send_byte(8'hFE, 1'b0);
		repeat (6) send_byte(8'hBF, 1'b1);
		send_byte(8'h00, 1'b0);
		wait_units_out(6);

		// Counted mode: zero code point, eight-byte lead, mode switch mid-sequence.
		write_mode(1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		for (c = 0; c < 7; c++)
			send_byte(8'hBF, c == 6);
		send_byte(8'hE2, 1'b1);
		wait_units_out(6);
		write_mode(1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hE2, 1'b1);
		wait_units_out(6);
		write_mode(1'b1);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'h41, 1'b1);
		wait_units_out(6);

		for (p = 0; p < 6; p++) begin
			write_mode(modes[p]);
			calm = (p == 2);
			if (p == 3)
				hold_req = 1'b1;
			goal = n_sent + 65;
			paused = 1'b0;
			while (n_sent < goal) begin
				nchars = mode_now ? $urandom_range(1, 6) : $urandom_range(0, 5);
				for (c = 0; c < nchars; c++)
					random_char(c == nchars - 1);
				if (!mode_now) begin
					if ($urandom_range(4) == 0) begin
						send_byte(8'hC0, 1'($urandom()));
						send_byte(8'h80, 1'($urandom()));
					end else begin
						send_byte(8'h00, 1'($urandom()));
					end
				end
				if (p == 4 && !paused && n_sent > goal - 35) begin
					paused = 1'b1;
					wait_units_out(4);
				end
			end
			wait_units_out(6);
		end

		calm = 1'b0;
		wait_units_out(10);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/utf8_to_utf16_stream.sv
rtl/u8u16_checker.sv
verif/tb.sv
